// File: rtl/bit_field_store_defines.svh
// Assertion macros shared by the bit field store RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef BIT_FIELD_STORE_DEFINES_SVH
`define BIT_FIELD_STORE_DEFINES_SVH

`ifndef SYNTHESIS

`define BFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFS_ASSERT_SAME(label, ante, cons, msg)

`define BFS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/bfs_pkg.sv
// Types and constants of the bit field store.
// No dependencies; used by every other file of the block but the defines header.
`default_nettype none

package bfs_pkg;

    localparam int POS_W       = 12;
    localparam int WIDTH_W     = 7;
    localparam int DATA_W      = 64;
    localparam int OP_W        = 3;
    localparam int FIELD_MAX   = 64;
    localparam int STORE_BITS_DEFAULT = 4096;

    // Highest word a field can touch is reached from the top bit position.
    localparam int REACH_WORDS = ((1 << POS_W) - 1 + FIELD_MAX - 1) / DATA_W + 1;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_INVERT = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd5;

    typedef struct packed {
        logic capture;
        logic commit;
    } bfs_cmd_t;

endpackage

`default_nettype wire

// File: rtl/bfs_req_if.sv
// Request channel of the bit field store: valid, ready and request payload.
// Depends on bfs_pkg for field widths.
`default_nettype none

interface bfs_req_if;
    logic                               valid;
    logic                               ready;
    logic [bfs_pkg::OP_W-1:0]           req_type;
    logic [bfs_pkg::POS_W-1:0]          bit_position;
    logic [bfs_pkg::WIDTH_W-1:0]        field_width;
    logic [bfs_pkg::DATA_W-1:0]         write_value;

    modport source (output valid, req_type, bit_position, field_width, write_value,
                    input ready);
    modport sink   (input valid, req_type, bit_position, field_width, write_value,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/bfs_rsp_if.sv
// Response channel of the bit field store: valid, ready and result payload.
// Depends on bfs_pkg for field widths.
`default_nettype none

interface bfs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bfs_pkg::DATA_W-1:0] read_data;
    logic                       out_of_range;

    modport source (output valid, read_data, out_of_range, input ready);
    modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

`default_nettype wire

// File: rtl/bit_field_store.sv
// Bit field store: an accepted request is captured with both words of its field read from
// the even and odd banks; the commit step then merges and writes them back and registers
// the result beat; fill takes the same path. No new request is taken until the commit.
// A waiting result stalls the next request's write-back until it is taken.
// Reset clears the word valid bits and the fill bit at once; no clearing pass is needed.
`default_nettype none

module bit_field_store #(
    parameter int STORE_BITS = bfs_pkg::STORE_BITS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfs_req_if.sink     req,
    bfs_rsp_if.source   rsp
);

    bfs_pkg::bfs_cmd_t cmd;

    bfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    bfs_datapath #(
        .STORE_BITS (STORE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .bit_position (req.bit_position),
        .field_width  (req.field_width),
        .write_value  (req.write_value),
        .read_data    (rsp.read_data),
        .out_of_range (rsp.out_of_range)
    );

endmodule

`default_nettype wire

// File: rtl/bfs_ctrl.sv
// Controller of the bit field store: two-state sequencer and result valid flag.
// Depends on bfs_pkg and bit_field_store_defines.svh.
`default_nettype none

`include "bit_field_store_defines.svh"

module bfs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bfs_pkg::bfs_cmd_t      cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_MODIFY = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;

    assign in_ready    = (state_reg == ST_IDLE);
    assign advance     = !out_valid_reg || out_ready;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == ST_MODIFY) && advance;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BFS_ASSERT_SAME(a_capture_commit_apart, cmd.capture, !cmd.commit, "capture and commit overlap")
    `BFS_ASSERT_NEXT(a_capture_then_modify, cmd.capture, state_reg == ST_MODIFY, "no modify after capture")
    `BFS_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_reg, "result lost after commit")
    `BFS_ASSERT_SAME(a_commit_has_room, cmd.commit, !out_valid_reg || out_ready, "result overwritten")

endmodule

`default_nettype wire

// File: rtl/bfs_datapath.sv
// Datapath of the bit field store: two word banks, valid bits, field merge and result.
// Depends on bfs_pkg and bit_field_store_defines.svh.
`default_nettype none

`include "bit_field_store_defines.svh"

module bfs_datapath #(
    parameter int STORE_BITS = bfs_pkg::STORE_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bfs_pkg::bfs_cmd_t              cmd,
    input  wire logic [bfs_pkg::OP_W-1:0]       req_type,
    input  wire logic [bfs_pkg::POS_W-1:0]      bit_position,
    input  wire logic [bfs_pkg::WIDTH_W-1:0]    field_width,
    input  wire logic [bfs_pkg::DATA_W-1:0]     write_value,
    output logic [bfs_pkg::DATA_W-1:0]          read_data,
    output logic                                out_of_range
);

    localparam int WORD_COUNT = (STORE_BITS + bfs_pkg::DATA_W - 1) / bfs_pkg::DATA_W;
    localparam int MEM_WORDS  = (WORD_COUNT < bfs_pkg::REACH_WORDS) ?
                                WORD_COUNT : bfs_pkg::REACH_WORDS;
    localparam int BANK_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WORD_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int LAST_BITS  = STORE_BITS - (WORD_COUNT - 1) * bfs_pkg::DATA_W;
    localparam logic [bfs_pkg::DATA_W-1:0] ONES = {bfs_pkg::DATA_W{1'b1}};
    localparam logic [bfs_pkg::DATA_W-1:0] LAST_MASK = ~(ONES << LAST_BITS);

    typedef logic [6:0] word_t;
    typedef logic [bfs_pkg::DATA_W-1:0] data_t;
    typedef logic [2*bfs_pkg::DATA_W-1:0] window_t;

    function automatic logic word_stored(input word_t w);
        return 32'(w) < MEM_WORDS;
    endfunction

    function automatic data_t word_mask(input word_t w);
        data_t m;
        if (32'(w) < WORD_COUNT - 1)
        begin
            m = ONES;
        end
        else if (32'(w) == WORD_COUNT - 1)
        begin
            m = LAST_MASK;
        end
        else
        begin
            m = '0;
        end
        return m;
    endfunction

    data_t even_mem [BANK_DEPTH];
    data_t odd_mem  [BANK_DEPTH];

    logic [MEM_WORDS-1:0]       vld_reg;
    logic                       fill_bit_reg;
    logic [bfs_pkg::OP_W-1:0]   op_reg;
    logic [5:0]                 off_reg;
    logic [5:0]                 wl_reg;
    data_t                      fm_reg;
    data_t                      val_reg;
    data_t                      even_rd_reg;
    data_t                      odd_rd_reg;
    logic                       even_vld_reg;
    logic                       odd_vld_reg;
    data_t                      read_data_reg;
    data_t                      read_data_next;
    logic                       oor_reg;
    logic                       oor_next;

    // Request side: the field's low word and the word after it, split by parity.
    word_t                      in_lo_w;
    word_t                      in_hi_w;
    word_t                      in_even_w;
    word_t                      in_odd_w;
    logic [bfs_pkg::WIDTH_W-1:0] w_sat;
    data_t                      fm_in;

    assign in_lo_w   = {1'b0, bit_position[11:6]};
    assign in_hi_w   = in_lo_w + 7'd1;
    assign in_even_w = bit_position[6] ? in_hi_w : in_lo_w;
    assign in_odd_w  = bit_position[6] ? in_lo_w : in_hi_w;
    assign w_sat     = (field_width > 7'd64) ? 7'd64 : field_width;
    assign fm_in     = ~(ONES << w_sat);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= req_type;
            off_reg      <= bit_position[5:0];
            wl_reg       <= bit_position[11:6];
            fm_reg       <= fm_in;
            val_reg      <= write_value;
            even_rd_reg  <= even_mem[in_even_w[BANK_AW:1]];
            odd_rd_reg   <= odd_mem[in_odd_w[BANK_AW:1]];
            even_vld_reg <= word_stored(in_even_w) && vld_reg[in_even_w[WORD_AW-1:0]];
            odd_vld_reg  <= word_stored(in_odd_w) && vld_reg[in_odd_w[WORD_AW-1:0]];
        end
    end

    // Modify side: merge the field into the two-word window.
    word_t   lo_w;
    word_t   hi_w;
    word_t   even_w;
    word_t   odd_w;
    data_t   even_word;
    data_t   odd_word;
    window_t win;
    window_t wm;
    window_t fsh;
    window_t vsh;
    window_t eff;
    window_t new_win;
    window_t rd_full;
    data_t   new_even;
    data_t   new_odd;
    logic    do_mod;
    logic    do_fill;

    assign lo_w      = {1'b0, wl_reg};
    assign hi_w      = lo_w + 7'd1;
    assign even_w    = wl_reg[0] ? hi_w : lo_w;
    assign odd_w     = wl_reg[0] ? lo_w : hi_w;
    assign even_word = even_vld_reg ? even_rd_reg : {bfs_pkg::DATA_W{fill_bit_reg}};
    assign odd_word  = odd_vld_reg ? odd_rd_reg : {bfs_pkg::DATA_W{fill_bit_reg}};
    assign win       = wl_reg[0] ? {even_word, odd_word} : {odd_word, even_word};
    assign wm        = {word_mask(hi_w), word_mask(lo_w)};
    assign fsh       = {{bfs_pkg::DATA_W{1'b0}}, fm_reg} << off_reg;
    assign vsh       = {{bfs_pkg::DATA_W{1'b0}}, val_reg & fm_reg} << off_reg;
    assign eff       = fsh & wm;
    assign rd_full   = (win & eff) >> off_reg;

    always_comb
    begin
        case (op_reg)
            bfs_pkg::OP_WRITE:  new_win = (win & ~eff) | (vsh & eff);
            bfs_pkg::OP_SET:    new_win = win | eff;
            bfs_pkg::OP_CLEAR:  new_win = win & ~eff;
            bfs_pkg::OP_INVERT: new_win = win ^ eff;
            default:            new_win = win;
        endcase
    end

    assign new_even = wl_reg[0] ? new_win[127:64] : new_win[63:0];
    assign new_odd  = wl_reg[0] ? new_win[63:0] : new_win[127:64];
    assign do_mod   = cmd.commit && (op_reg inside {bfs_pkg::OP_WRITE, bfs_pkg::OP_SET,
                                                   bfs_pkg::OP_CLEAR, bfs_pkg::OP_INVERT});
    assign do_fill  = cmd.commit && (op_reg == bfs_pkg::OP_FILL);

    assign read_data_next = (op_reg == bfs_pkg::OP_READ) ? rd_full[63:0] : '0;
    assign oor_next       = (op_reg <= bfs_pkg::OP_INVERT) && (|(fsh & ~wm));

    always_ff @(posedge clk)
    begin
        if (do_mod && word_stored(even_w))
        begin
            even_mem[even_w[BANK_AW:1]] <= new_even;
        end
        if (do_mod && word_stored(odd_w))
        begin
            odd_mem[odd_w[BANK_AW:1]] <= new_odd;
        end
        if (cmd.commit)
        begin
            read_data_reg <= read_data_next;
            oor_reg       <= oor_next;
        end
    end

    // A word without its valid bit holds the last fill value in every bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            fill_bit_reg <= 1'b0;
        end
        else if (do_fill)
        begin
            vld_reg      <= '0;
            fill_bit_reg <= val_reg[0];
        end
        else if (do_mod)
        begin
            if (word_stored(even_w))
            begin
                vld_reg[even_w[WORD_AW-1:0]] <= 1'b1;
            end
            if (word_stored(odd_w))
            begin
                vld_reg[odd_w[WORD_AW-1:0]] <= 1'b1;
            end
        end
    end

    assign read_data    = read_data_reg;
    assign out_of_range = oor_reg;

    `BFS_ASSERT_NEXT(a_fill_clears_valid, do_fill, vld_reg == '0, "valid bits survive a fill")
    `BFS_ASSERT_SAME(a_fill_no_modify, do_fill, !do_mod, "fill and modify in one cycle")

endmodule

`default_nettype wire
